FILE: rtl/bhpq_pkg.sv
// Shared types, constants and helpers of the binary heap priority queue.
// Used by bhpq_ctrl and binary_heap_priority_queue_top; no dependencies.
package bhpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int CHILD_BITS = ADDR_BITS + 2;
  localparam int PADDR_BITS = 3;

  // Operation codes.
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Register word index of min_first.
  localparam logic REG_MIN_FIRST = 1'b0;

  typedef struct packed {
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key_in;
  } in_req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_out;
    logic [1:0]          status;
    logic [CNT_BITS-1:0] count_out;
  } out_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [KEY_BITS-1:0]  wdata;
    logic [ADDR_BITS-1:0] raddr0;
    logic [ADDR_BITS-1:0] raddr1;
  } ram_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEEK,
    ST_UP,
    ST_UP_FIN,
    ST_POP_LOAD,
    ST_DOWN,
    ST_DOWN_FIN,
    ST_DONE
  } ctrl_state_t;

  // True when key a is served before key b.
  function automatic logic served_first(input logic min_first,
                                        input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b);
    served_first = min_first ? (a < b) : (a > b);
  endfunction

  // Left child index of a heap position, wide enough for any child.
  function automatic logic [CHILD_BITS-1:0] left_of(input logic [ADDR_BITS-1:0] pos);
    left_of = CHILD_BITS'({pos, 1'b1});
  endfunction

endpackage

FILE: rtl/bhpq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module bhpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/bhpq_ctrl.sv
// Heap sequencer: takes one request, reads the root for a peek or runs sift-up or sift-down over the heap RAM.
// Depends on bhpq_pkg; drives the RAM command struct and reads both RAM ports.
module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                min_first,
  input  logic                in_valid,
  input  in_req_t             in_data,
  output logic                in_stall,
  input  logic                slot_free,
  output logic                rsp_valid,
  output out_rsp_t            rsp_data,
  output ram_cmd_t            ram_cmd,
  input  logic [KEY_BITS-1:0] rd0,
  input  logic [KEY_BITS-1:0] rd1
);

  ctrl_state_t          state_r, state_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0] pos_r, pos_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  out_rsp_t             rsp_r, rsp_nxt;

  logic [CHILD_BITS-1:0] left_c, right_c, n_ext, next_left;
  logic [ADDR_BITS-1:0]  parent_c, best_idx;
  logic [KEY_BITS-1:0]   best_val;
  logic                  moved;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    rsp_r <= rsp_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign rsp_valid = (state_r == ST_DONE);
  assign rsp_data  = rsp_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    rsp_nxt   = rsp_r;
    ram_cmd   = '0;

    left_c    = left_of(pos_r);
    right_c   = left_c + CHILD_BITS'(1);
    n_ext     = CHILD_BITS'(cnt_r);
    parent_c  = (pos_r - ADDR_BITS'(1)) >> 1;
    best_idx  = pos_r;
    best_val  = key_r;
    moved     = 1'b0;
    next_left = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt           = in_data.key_in;
          rsp_nxt.key_out   = '0;
          rsp_nxt.status    = STATUS_OK;
          rsp_nxt.count_out = cnt_r;
          state_nxt         = ST_DONE;
          if (in_data.func == FUNC_PUSH) begin
            if (cnt_r >= CNT_BITS'(CAPACITY)) begin
              rsp_nxt.status = STATUS_FULL;
            end else begin
              cnt_nxt           = cnt_r + CNT_BITS'(1);
              rsp_nxt.count_out = cnt_r + CNT_BITS'(1);
              pos_nxt           = cnt_r[ADDR_BITS-1:0];
              if (cnt_r == '0) begin
                // Empty heap: the key lands at the root directly.
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = '0;
                ram_cmd.wdata = in_data.key_in;
              end else begin
                ram_cmd.raddr0 = (cnt_r[ADDR_BITS-1:0] - ADDR_BITS'(1)) >> 1;
                state_nxt      = ST_UP;
              end
            end
          end else if (in_data.func == FUNC_POP || in_data.func == FUNC_PEEK) begin
            if (cnt_r == '0) begin
              rsp_nxt.status = STATUS_EMPTY;
            end else if (in_data.func == FUNC_PEEK) begin
              ram_cmd.raddr0 = '0;
              state_nxt      = ST_PEEK;
            end else begin
              // Fetch root and last entry together.
              ram_cmd.raddr0    = '0;
              ram_cmd.raddr1    = ADDR_BITS'(cnt_r - CNT_BITS'(1));
              cnt_nxt           = cnt_r - CNT_BITS'(1);
              rsp_nxt.count_out = cnt_r - CNT_BITS'(1);
              state_nxt         = ST_POP_LOAD;
            end
          end
        end
      end

      ST_PEEK: begin
        rsp_nxt.key_out = rd0;
        state_nxt       = ST_DONE;
      end

      ST_UP: begin
        // rd0 holds the parent of the hole at pos_r.
        ram_cmd.we = 1'b1;
        ram_cmd.waddr = pos_r;
        if (served_first(min_first, key_r, rd0)) begin
          ram_cmd.wdata = rd0;
          pos_nxt       = parent_c;
          if (parent_c == '0) begin
            state_nxt = ST_UP_FIN;
          end else begin
            ram_cmd.raddr0 = (parent_c - ADDR_BITS'(1)) >> 1;
          end
        end else begin
          ram_cmd.wdata = key_r;
          state_nxt     = ST_DONE;
        end
      end

      ST_UP_FIN: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = pos_r;
        ram_cmd.wdata = key_r;
        state_nxt     = ST_DONE;
      end

      ST_POP_LOAD: begin
        rsp_nxt.key_out = rd0;
        key_nxt         = rd1;
        pos_nxt         = '0;
        if (left_of('0) >= n_ext) begin
          ram_cmd.we    = 1'b1;
          ram_cmd.waddr = '0;
          ram_cmd.wdata = rd1;
          state_nxt     = ST_DONE;
        end else begin
          ram_cmd.raddr0 = ADDR_BITS'(left_of('0));
          ram_cmd.raddr1 = ADDR_BITS'(left_of('0) + CHILD_BITS'(1));
          state_nxt      = ST_DOWN;
        end
      end

      ST_DOWN: begin
        // rd0 and rd1 hold the left and right child of the hole.
        if (left_c < n_ext && served_first(min_first, rd0, best_val)) begin
          best_val = rd0;
          best_idx = left_c[ADDR_BITS-1:0];
          moved    = 1'b1;
        end
        if (right_c < n_ext && served_first(min_first, rd1, best_val)) begin
          best_val = rd1;
          best_idx = right_c[ADDR_BITS-1:0];
          moved    = 1'b1;
        end
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = pos_r;
        ram_cmd.wdata = best_val;
        next_left     = left_of(best_idx);
        if (!moved) begin
          state_nxt = ST_DONE;
        end else begin
          pos_nxt = best_idx;
          if (next_left >= n_ext) begin
            state_nxt = ST_DOWN_FIN;
          end else begin
            ram_cmd.raddr0 = next_left[ADDR_BITS-1:0];
            ram_cmd.raddr1 = ADDR_BITS'(next_left + CHILD_BITS'(1));
          end
        end
      end

      ST_DOWN_FIN: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = pos_r;
        ram_cmd.wdata = key_r;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/binary_heap_priority_queue_top.sv
// Binary heap priority queue: top level with APB register, output register,
// heap sequencer and heap RAM. Depends on bhpq_pkg, bhpq_ram and bhpq_ctrl.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request: push a key,
//   pop the top key or peek at it. Every request yields exactly one response on
//   the output channel (out_valid/out_stall/out_data) with the top key (pops and
//   peeks), a status (ok, empty, full) and the count after the request.
//   One request is in flight at a time; in_stall is high while it is worked on.
//   During a push or pop the moving key climbs or sinks at most log2(CAPACITY)
//   levels. The write of the moved entry overlaps the read of the next level,
//   and the moving key stays in a register, so no access touches an entry that
//   is written in the same cycle. A new request is taken in the cycle after the
//   response is handed off.
//   The response waits in an output register while out_stall is high; the next
//   request is accepted meanwhile and its response holds in the sequencer.
//   Reset clears the count (heap empty) and sets min_first to 0 (largest first).
//   min_first sits at APB byte address 0. It is to be written by the user only
//   while idle; the block itself does not enforce this.
module binary_heap_priority_queue_top
  import bhpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  // response channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_rsp_t              out_data,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic     min_first_r;
  logic     out_valid_r;
  out_rsp_t out_data_r;

  logic                slot_free;
  logic                rsp_valid;
  out_rsp_t            rsp_data;
  ram_cmd_t            ram_cmd;
  logic [KEY_BITS-1:0] rd0, rd1;
  logic                reg_hit;

  // Register port: zero wait states, one word.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_BITS-1:2] == (PADDR_BITS-2)'(REG_MIN_FIRST));
  assign prdata  = reg_hit ? {31'b0, min_first_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_first_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      min_first_r <= pwdata[0];
    end
  end

  // Output register: load when empty or when the held response leaves.
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && slot_free) begin
      out_data_r <= rsp_data;
    end
  end

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_first (min_first_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .slot_free (slot_free),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .ram_cmd   (ram_cmd),
    .rd0       (rd0),
    .rd1       (rd1)
  );

  bhpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS)
  ) u_ram (
    .clk    (clk),
    .we     (ram_cmd.we),
    .waddr  (ram_cmd.waddr),
    .wdata  (ram_cmd.wdata),
    .raddr0 (ram_cmd.raddr0),
    .raddr1 (ram_cmd.raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

endmodule
